FILE: hw/rtl/sfp_pkg.sv
// shared types, codes and helpers for the serial frame parser
package sfp_pkg;

  localparam int unsigned PhaseW = 3;
  localparam int unsigned KindW  = 2;
  localparam int unsigned ByteW  = 8;

  // parser phases
  localparam logic [PhaseW-1:0] PH_HUNT = 3'd0;
  localparam logic [PhaseW-1:0] PH_ID   = 3'd1;
  localparam logic [PhaseW-1:0] PH_LEN  = 3'd2;
  localparam logic [PhaseW-1:0] PH_DATA = 3'd3;
  localparam logic [PhaseW-1:0] PH_END  = 3'd4;

  // result kinds
  localparam logic [KindW-1:0] EV_NONE = 2'd0;
  localparam logic [KindW-1:0] EV_DATA = 2'd1;
  localparam logic [KindW-1:0] EV_DONE = 2'd2;
  localparam logic [KindW-1:0] EV_ERR  = 2'd3;

  localparam logic [ByteW-1:0] START_BYTE = 8'hFF;
  localparam logic [ByteW-1:0] END_BYTE   = 8'hFE;

  localparam logic [ByteW-1:0] ID_A = 8'h05;
  localparam logic [ByteW-1:0] ID_B = 8'h16;
  localparam logic [ByteW-1:0] ID_C = 8'h27;
  localparam logic [ByteW-1:0] ID_D = 8'h38;
  localparam logic [ByteW-1:0] ID_E = 8'h49;
  localparam logic [ByteW-1:0] ID_F = 8'h5A;
  localparam logic [ByteW-1:0] ID_G = 8'h00;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [ByteW-1:0]  held_id;
    logic [ByteW-1:0]  held_length;
    logic [ByteW-1:0]  payload_count;
  } parse_state_t;

  typedef struct packed {
    logic [KindW-1:0] event_kind;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] byte_index;
    logic [ByteW-1:0] frame_id;
    logic [ByteW-1:0] frame_length;
  } parse_result_t;

  function automatic logic id_allowed(input logic [ByteW-1:0] b);
    id_allowed = (b == ID_A) || (b == ID_B) || (b == ID_C) || (b == ID_D) ||
                 (b == ID_E) || (b == ID_F) || (b == ID_G);
  endfunction

endpackage

FILE: hw/rtl/sfp_parse_core.sv
// per-byte parse logic: next parser state and the result for one byte
module sfp_parse_core (
  input  sfp_pkg::parse_state_t  state_cur,
  input  logic [7:0]             rx_byte,
  input  logic                   last_in_buffer,
  output sfp_pkg::parse_state_t  state_nxt,
  output sfp_pkg::parse_result_t result
);

  logic [7:0] count_inc;
  logic       is_start;

  assign count_inc = state_cur.payload_count + 8'd1;
  assign is_start  = (rx_byte == sfp_pkg::START_BYTE);

  always_comb begin
    state_nxt = state_cur;
    result    = '0;
    result.event_kind = sfp_pkg::EV_NONE;
    unique case (state_cur.phase)
      sfp_pkg::PH_ID: begin
        if (sfp_pkg::id_allowed(rx_byte)) begin
          state_nxt.held_id = rx_byte;
          state_nxt.phase   = sfp_pkg::PH_LEN;
        end else if (is_start) begin
          state_nxt.phase = sfp_pkg::PH_ID;
        end else begin
          result.event_kind = sfp_pkg::EV_ERR;
          state_nxt.phase   = sfp_pkg::PH_HUNT;
        end
      end
      sfp_pkg::PH_LEN: begin
        state_nxt.held_length   = rx_byte;
        state_nxt.payload_count = '0;
        state_nxt.phase = (rx_byte == 8'd0) ? sfp_pkg::PH_END : sfp_pkg::PH_DATA;
      end
      sfp_pkg::PH_DATA: begin
        result.event_kind   = sfp_pkg::EV_DATA;
        result.data_byte    = rx_byte;
        result.byte_index   = state_cur.payload_count;
        result.frame_id     = state_cur.held_id;
        result.frame_length = state_cur.held_length;
        state_nxt.payload_count = count_inc;
        if (count_inc == state_cur.held_length) begin
          state_nxt.phase = sfp_pkg::PH_END;
        end
      end
      sfp_pkg::PH_END: begin
        if (rx_byte == sfp_pkg::END_BYTE) begin
          result.event_kind   = sfp_pkg::EV_DONE;
          result.frame_id     = state_cur.held_id;
          result.frame_length = state_cur.held_length;
          state_nxt.phase     = sfp_pkg::PH_HUNT;
        end else begin
          // second look at the offending byte as a hunting byte
          result.event_kind = sfp_pkg::EV_ERR;
          state_nxt.phase   = is_start ? sfp_pkg::PH_ID : sfp_pkg::PH_HUNT;
        end
      end
      default: begin
        if (is_start) begin
          state_nxt.phase = sfp_pkg::PH_ID;
        end else begin
          result.event_kind = sfp_pkg::EV_ERR;
          state_nxt.phase   = sfp_pkg::PH_HUNT;
        end
      end
    endcase
    if (last_in_buffer) begin
      state_nxt = '0;
    end
  end

endmodule

FILE: hw/rtl/serial_frame_parser_unit.sv
// top level of the serial frame parser: input register, parse logic, result register
// One result transaction comes out for every input byte, in order. A byte passes
// an input register, one pass of the parse logic and a result register, and it
// moves on to the result register only when that is free or being drained. The
// block takes a new byte every cycle while the result side keeps up. The parse state
// updates once per byte as the byte moves from the input to the result register.
module serial_frame_parser_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_last_in_buffer,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_kind,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_byte_index,
  output logic [7:0] out_frame_id,
  output logic [7:0] out_frame_length
);

  logic                  in_valid_r;
  logic [7:0]            rx_byte_r;
  logic                  last_r;
  logic                  out_valid_r;
  sfp_pkg::parse_result_t result_r;
  sfp_pkg::parse_state_t  state_r;
  sfp_pkg::parse_state_t  state_nxt;
  sfp_pkg::parse_result_t result_nxt;
  logic                  advance;

  sfp_parse_core u_core (
    .state_cur      (state_r),
    .rx_byte        (rx_byte_r),
    .last_in_buffer (last_r),
    .state_nxt      (state_nxt),
    .result         (result_nxt)
  );

  // the input register moves on when the result register is free or being drained
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rx_byte_r <= in_rx_byte;
      last_r    <= in_last_in_buffer;
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = result_r.event_kind;
  assign out_data_byte    = result_r.data_byte;
  assign out_byte_index   = result_r.byte_index;
  assign out_frame_id     = result_r.frame_id;
  assign out_frame_length = result_r.frame_length;

endmodule
